@@ rtl/core/fps_pkg.sv @@
`timescale 1ns / 1ps

package fps_pkg;

  // payload and register widths
  localparam int VALUE_BITS    = 32;
  localparam int COEFF_BITS    = 32;
  localparam int DIM_BITS      = 11;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  // Q16.16 arithmetic
  localparam int FRAC_BITS = 16;
  localparam int SUM_BITS  = VALUE_BITS + 1;        // pair of neighbors
  localparam int PROD_BITS = COEFF_BITS + SUM_BITS; // coeff * pair
  localparam int ACC_BITS  = PROD_BITS + 2;         // three products

  localparam int MIN_DIM        = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_BITS-1:0]   RST_GRID_WIDTH   = 11'd51;
  localparam logic [DIM_BITS-1:0]   RST_GRID_HEIGHT  = 11'd51;
  localparam logic [COEFF_BITS-1:0] RST_CENTER_COEFF = 32'h0069_0000;
  localparam logic [COEFF_BITS-1:0] RST_HORIZ_COEFF  = 32'hFFE7_0000;
  localparam logic [COEFF_BITS-1:0] RST_VERT_COEFF   = 32'hFFE7_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_CENTER_COEFF = 3'd2,
    REG_HORIZ_COEFF  = 3'd3,
    REG_VERT_COEFF   = 3'd4
  } cfg_reg_t;

  // five stencil taps around one center point
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] center;
    logic signed [VALUE_BITS-1:0] left;
    logic signed [VALUE_BITS-1:0] right;
    logic signed [VALUE_BITS-1:0] down;
    logic signed [VALUE_BITS-1:0] up;
  } taps_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] center;
    logic signed [COEFF_BITS-1:0] horiz;
    logic signed [COEFF_BITS-1:0] vert;
  } coeffs_t;

endpackage

@@ rtl/core/five_point_stencil_operator.sv @@
`timescale 1ns / 1ps
// Results of a word pass kernel stages s0, s1, s2 and then the output register.
// Throughput: one word per cycle while in_ready is high; a word that completes
//   an interior point and is itself a boundary point gives two result words.
// A config write holds off the input (cfg_hold_r) while the line stores reread.
// Reset (sync, active low) clears the position counters, the pipeline and the
//   config registers to defaults; the line stores are not cleared.
module five_point_stencil_operator #(
  parameter int MAX_WIDTH  = fps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_wr_en,
  input  logic [fps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fps_pkg::VALUE_BITS-1:0] in_sample_value,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fps_pkg::VALUE_BITS-1:0] out_result_value,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_result_column,
  output logic [$clog2(MAX_HEIGHT)-1:0]       out_result_row,
  output logic                                out_last_in_step
);
  import fps_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int SH_BITS = ACC_BITS - FRAC_BITS;
  localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  // per-word info that rides along the arithmetic pipeline
  typedef struct packed {
    logic                  has_int;
    logic                  has_bnd;
    logic [VALUE_BITS-1:0] sample;
    logic [CW-1:0]         col;
    logic [RW-1:0]         row;
  } tag_t;

  localparam int TAG_BITS = $bits(tag_t);

  // ---------------------------------------------------------------------------
  // Config registers. A write blocks input via cfg_hold_r so the line store
  // read for the (possibly re-wrapped) position is redone with the new size.
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0]   grid_width_r,   grid_width_nxt;
  logic [DIM_BITS-1:0]   grid_height_r,  grid_height_nxt;
  logic [COEFF_BITS-1:0] center_coeff_r, center_coeff_nxt;
  logic [COEFF_BITS-1:0] horiz_coeff_r,  horiz_coeff_nxt;
  logic [COEFF_BITS-1:0] vert_coeff_r,   vert_coeff_nxt;
  logic                  cfg_hold_r,     cfg_hold_nxt;

  always_comb begin
    grid_width_nxt   = grid_width_r;
    grid_height_nxt  = grid_height_r;
    center_coeff_nxt = center_coeff_r;
    horiz_coeff_nxt  = horiz_coeff_r;
    vert_coeff_nxt   = vert_coeff_r;
    cfg_hold_nxt     = cfg_wr_en;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:   grid_width_nxt   = cfg_wdata[DIM_BITS-1:0];
        REG_GRID_HEIGHT:  grid_height_nxt  = cfg_wdata[DIM_BITS-1:0];
        REG_CENTER_COEFF: center_coeff_nxt = cfg_wdata[COEFF_BITS-1:0];
        REG_HORIZ_COEFF:  horiz_coeff_nxt  = cfg_wdata[COEFF_BITS-1:0];
        REG_VERT_COEFF:   vert_coeff_nxt   = cfg_wdata[COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= RST_GRID_WIDTH;
      grid_height_r  <= RST_GRID_HEIGHT;
      center_coeff_r <= RST_CENTER_COEFF;
      horiz_coeff_r  <= RST_HORIZ_COEFF;
      vert_coeff_r   <= RST_VERT_COEFF;
      cfg_hold_r     <= 1'b0;
    end else begin
      grid_width_r   <= grid_width_nxt;
      grid_height_r  <= grid_height_nxt;
      center_coeff_r <= center_coeff_nxt;
      horiz_coeff_r  <= horiz_coeff_nxt;
      vert_coeff_r   <= vert_coeff_nxt;
      cfg_hold_r     <= cfg_hold_nxt;
    end
  end

  // effective grid size, clamped to [3, MAX]
  logic [CW:0] width_eff;
  logic [RW:0] height_eff;

  always_comb begin
    if (grid_width_r < DIM_BITS'(MIN_DIM)) begin
      width_eff = (CW+1)'(MIN_DIM);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(grid_width_r);
    end
    if (grid_height_r < DIM_BITS'(MIN_DIM)) begin
      height_eff = (RW+1)'(MIN_DIM);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      height_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      height_eff = (RW+1)'(grid_height_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position. The stored counters are re-wrapped against the current
  // size (only matters after a size change mid-grid), giving col_pos/row_pos.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_pos, col_adv;
  logic [RW-1:0] row_pos, row_adv;
  logic [RW:0]   row_step, row_inc;
  logic [CW:0]   col_inc;
  logic          has_int, has_bnd, in_acc;

  always_comb begin
    col_pos  = col_cnt_r;
    row_step = {1'b0, row_cnt_r};
    if ({1'b0, col_cnt_r} >= width_eff) begin
      col_pos  = '0;
      row_step = {1'b0, row_cnt_r} + (RW+1)'(1);
    end
    row_pos = (row_step >= height_eff) ? '0 : row_step[RW-1:0];
  end

  // position that follows col_pos/row_pos
  always_comb begin
    col_inc = {1'b0, col_pos} + (CW+1)'(1);
    row_inc = {1'b0, row_pos} + (RW+1)'(1);
    if (col_inc >= width_eff) begin
      col_adv = '0;
      row_adv = (row_inc >= height_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_adv = col_inc[CW-1:0];
      row_adv = row_pos;
    end
  end

  // the arriving word completes interior point (col, row-1)
  assign has_int = (row_pos >= RW'(2)) && (col_pos != '0)
                && (({1'b0, col_pos} + (CW+1)'(2)) <= width_eff);
  assign has_bnd = (col_pos == '0) || ({1'b0, col_pos} == width_eff - (CW+1)'(1))
                || (row_pos == '0) || ({1'b0, row_pos} == height_eff - (RW+1)'(1));

  always_comb begin
    col_cnt_nxt = in_acc ? col_adv : col_cnt_r;
    row_cnt_nxt = in_acc ? row_adv : row_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Reads run every cycle for the position the next word will
  // take, so taps are registered and ready when that word arrives. The left
  // tap is the center of the previous word in the row.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         rd_col;
  logic [VALUE_BITS-1:0] rd_center, rd_right, rd_down;
  logic [VALUE_BITS-1:0] left_r;

  assign rd_col = in_acc ? col_adv : col_pos;

  fps_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_col    (rd_col),
    .wr_en     (in_acc),
    .wr_col    (col_pos),
    .wr_up     (in_sample_value),
    .wr_mid    (rd_center),
    .rd_center (rd_center),
    .rd_right  (rd_right),
    .rd_down   (rd_down)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r <= rd_center;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic pipeline. Only words that produce a result enter it.
  // ---------------------------------------------------------------------------
  logic                       k_in_valid, k_in_ready;
  logic                       k_out_valid, k_out_ready;
  logic signed [ACC_BITS-1:0] k_out_acc;
  logic [TAG_BITS-1:0]        k_out_tag_bits;
  taps_t                      taps;
  coeffs_t                    coeffs;
  tag_t                       in_tag, k_tag;

  assign in_ready   = !cfg_hold_r && (k_in_ready || !(has_int || has_bnd));
  assign in_acc     = in_valid && in_ready;
  assign k_in_valid = in_valid && !cfg_hold_r && (has_int || has_bnd);

  always_comb begin
    taps.center    = rd_center;
    taps.left      = left_r;
    taps.right     = rd_right;
    taps.down      = rd_down;
    taps.up        = in_sample_value;
    coeffs.center  = center_coeff_r;
    coeffs.horiz   = horiz_coeff_r;
    coeffs.vert    = vert_coeff_r;
    in_tag.has_int = has_int;
    in_tag.has_bnd = has_bnd;
    in_tag.sample  = in_sample_value;
    in_tag.col     = col_pos;
    in_tag.row     = row_pos;
  end

  fps_kernel #(
    .TAG_BITS (TAG_BITS)
  ) u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (k_in_valid),
    .in_ready  (k_in_ready),
    .in_taps   (taps),
    .in_tag    (in_tag),
    .coeffs    (coeffs),
    .out_valid (k_out_valid),
    .out_ready (k_out_ready),
    .out_acc   (k_out_acc),
    .out_tag   (k_out_tag_bits)
  );

  assign k_tag = tag_t'(k_out_tag_bits);

  // round half up, drop fraction, saturate to the value range
  logic [ACC_BITS-1:0]   acc_rnd;
  logic [SH_BITS-1:0]    acc_sh;
  logic [VALUE_BITS-1:0] res_sat;

  always_comb begin
    acc_rnd = k_out_acc + ROUND_HALF;
    acc_sh  = acc_rnd[ACC_BITS-1:FRAC_BITS];
    if ((&acc_sh[SH_BITS-1:VALUE_BITS-1]) || !(|acc_sh[SH_BITS-1:VALUE_BITS-1])) begin
      res_sat = acc_sh[VALUE_BITS-1:0];
    end else if (acc_sh[SH_BITS-1]) begin
      res_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: up to two result words per input word, interior first.
  // ---------------------------------------------------------------------------
  logic                  o_v_r, o_v_nxt;
  logic                  o_pi_r, o_pi_nxt;
  logic                  o_pb_r, o_pb_nxt;
  logic [VALUE_BITS-1:0] o_res_r;
  logic [VALUE_BITS-1:0] o_x_r;
  logic [CW-1:0]         o_col_r;
  logic [RW-1:0]         o_row_r;
  logic                  o_load;

  assign k_out_ready = !o_v_r || (out_ready && !(o_pi_r && o_pb_r));
  assign o_load      = k_out_valid && k_out_ready;

  always_comb begin
    o_v_nxt  = o_v_r;
    o_pi_nxt = o_pi_r;
    o_pb_nxt = o_pb_r;
    if (o_load) begin
      o_v_nxt  = 1'b1;
      o_pi_nxt = k_tag.has_int;
      o_pb_nxt = k_tag.has_bnd;
    end else if (o_v_r && out_ready) begin
      if (o_pi_r && o_pb_r) begin
        o_pi_nxt = 1'b0;
      end else begin
        o_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      o_pi_r <= 1'b0;
      o_pb_r <= 1'b0;
    end else begin
      o_v_r  <= o_v_nxt;
      o_pi_r <= o_pi_nxt;
      o_pb_r <= o_pb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_res_r <= res_sat;
      o_x_r   <= k_tag.sample;
      o_col_r <= k_tag.col;
      o_row_r <= k_tag.row;
    end
  end

  assign out_valid         = o_v_r;
  assign out_result_value  = o_pi_r ? o_res_r : o_x_r;
  assign out_result_column = o_col_r;
  assign out_result_row    = o_pi_r ? (o_row_r - RW'(1)) : o_row_r;
  assign out_last_in_step  = !(o_pi_r && o_pb_r);

endmodule

@@ rtl/core/fps_line_buf.sv @@
`timescale 1ns / 1ps

module fps_line_buf #(
  parameter int MAX_WIDTH = fps_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic [$clog2(MAX_WIDTH)-1:0]        rd_col,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]        wr_col,
  input  logic [fps_pkg::VALUE_BITS-1:0]      wr_up,
  input  logic [fps_pkg::VALUE_BITS-1:0]      wr_mid,
  output logic [fps_pkg::VALUE_BITS-1:0]      rd_center,
  output logic [fps_pkg::VALUE_BITS-1:0]      rd_right,
  output logic [fps_pkg::VALUE_BITS-1:0]      rd_down
);
  import fps_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // cur_mem: most recent row, prev_mem: the row before it
  logic [VALUE_BITS-1:0] cur_mem  [MAX_WIDTH];
  logic [VALUE_BITS-1:0] prev_mem [MAX_WIDTH];

  logic [AW-1:0]         rd_next;
  logic [VALUE_BITS-1:0] rd_center_r;
  logic [VALUE_BITS-1:0] rd_right_r;
  logic [VALUE_BITS-1:0] rd_down_r;

  assign rd_next = rd_col + AW'(1);

  // the write column never equals a read column in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cur_mem[wr_col]  <= wr_up;
      prev_mem[wr_col] <= wr_mid;
    end
    rd_center_r <= cur_mem[rd_col];
    rd_right_r  <= cur_mem[rd_next];
    rd_down_r   <= prev_mem[rd_col];
  end

  assign rd_center = rd_center_r;
  assign rd_right  = rd_right_r;
  assign rd_down   = rd_down_r;

endmodule

@@ rtl/core/fps_kernel.sv @@
`timescale 1ns / 1ps

module fps_kernel #(
  parameter int TAG_BITS = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fps_pkg::taps_t                     in_taps,
  input  logic [TAG_BITS-1:0]                in_tag,
  input  fps_pkg::coeffs_t                   coeffs,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fps_pkg::ACC_BITS-1:0] out_acc,
  output logic [TAG_BITS-1:0]                out_tag
);
  import fps_pkg::*;

  // s0: neighbor pair sums, s1: products, s2: accumulated sum
  logic adv0, adv1, adv2;
  logic s0_v_r, s1_v_r, s2_v_r;
  logic s0_v_nxt, s1_v_nxt, s2_v_nxt;

  logic signed [VALUE_BITS-1:0] s0_cen_r, s0_cen_nxt;
  logic signed [SUM_BITS-1:0]   s0_hsum_r, s0_hsum_nxt;
  logic signed [SUM_BITS-1:0]   s0_vsum_r, s0_vsum_nxt;
  logic [TAG_BITS-1:0]          s0_tag_r;

  logic signed [VALUE_BITS+COEFF_BITS-1:0] s1_pc_r, s1_pc_nxt;
  logic signed [PROD_BITS-1:0]             s1_ph_r, s1_ph_nxt;
  logic signed [PROD_BITS-1:0]             s1_pv_r, s1_pv_nxt;
  logic [TAG_BITS-1:0]                     s1_tag_r;

  logic signed [ACC_BITS-1:0] s2_acc_r, s2_acc_nxt;
  logic [TAG_BITS-1:0]        s2_tag_r;

  assign adv2     = !s2_v_r || out_ready;
  assign adv1     = !s1_v_r || adv2;
  assign adv0     = !s0_v_r || adv1;
  assign in_ready = adv0;

  always_comb begin
    s0_v_nxt = adv0 ? in_valid : s0_v_r;
    s1_v_nxt = adv1 ? s0_v_r : s1_v_r;
    s2_v_nxt = adv2 ? s1_v_r : s2_v_r;
  end

  always_comb begin
    s0_cen_nxt  = in_taps.center;
    s0_hsum_nxt = {in_taps.left[VALUE_BITS-1], in_taps.left}
                + {in_taps.right[VALUE_BITS-1], in_taps.right};
    s0_vsum_nxt = {in_taps.down[VALUE_BITS-1], in_taps.down}
                + {in_taps.up[VALUE_BITS-1], in_taps.up};
    s1_pc_nxt   = s0_cen_r * coeffs.center;
    s1_ph_nxt   = s0_hsum_r * coeffs.horiz;
    s1_pv_nxt   = s0_vsum_r * coeffs.vert;
    s2_acc_nxt  = ACC_BITS'(s1_pc_r) + ACC_BITS'(s1_ph_r) + ACC_BITS'(s1_pv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      s0_cen_r  <= s0_cen_nxt;
      s0_hsum_r <= s0_hsum_nxt;
      s0_vsum_r <= s0_vsum_nxt;
      s0_tag_r  <= in_tag;
    end
    if (adv1 && s0_v_r) begin
      s1_pc_r  <= s1_pc_nxt;
      s1_ph_r  <= s1_ph_nxt;
      s1_pv_r  <= s1_pv_nxt;
      s1_tag_r <= s0_tag_r;
    end
    if (adv2 && s1_v_r) begin
      s2_acc_r <= s2_acc_nxt;
      s2_tag_r <= s1_tag_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_acc   = s2_acc_r;
  assign out_tag   = s2_tag_r;

endmodule

@@ verif/fps_stencil_checker.sv @@
`timescale 1ns / 1ps

module fps_stencil_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [fps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [fps_pkg::VALUE_BITS-1:0] in_sample_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [fps_pkg::VALUE_BITS-1:0] out_result_value,
  input  logic [$clog2(fps_pkg::DEF_MAX_WIDTH)-1:0]  out_result_column,
  input  logic [$clog2(fps_pkg::DEF_MAX_HEIGHT)-1:0] out_result_row,
  input  logic                                  out_last_in_step,
  output int                                    fail_count,
  output int                                    pending_results
);
  import fps_pkg::*;

  localparam int COLS     = DEF_MAX_WIDTH;
  localparam int ROWS     = DEF_MAX_HEIGHT;
  localparam int COL_BITS = $clog2(COLS);
  localparam int ROW_BITS = $clog2(ROWS);
  localparam int ACC_W    = 80;  // five 64-bit products fit with room to spare

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [COL_BITS-1:0]   column;
    logic [ROW_BITS-1:0]   row;
    logic                  last;
  } stencil_point_t;

  stencil_point_t expected_points [$];
  stencil_point_t want;

  // two most recent rows of the grid, indexed by column
  logic signed [VALUE_BITS-1:0] older_row [COLS];
  logic signed [VALUE_BITS-1:0] newer_row [COLS];

  logic [DIM_BITS-1:0]          width_cfg, height_cfg;
  logic signed [COEFF_BITS-1:0] center_k, horiz_k, vert_k;
  int unsigned                  col_pos = 0, row_pos = 0;
  int                           mismatches = 0;
  int                           waiting = 0;

  assign fail_count      = mismatches;
  assign pending_results = waiting;

  function automatic int unsigned dim_limit(input logic [DIM_BITS-1:0] v,
                                            input int unsigned ceiling);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  function automatic logic signed [ACC_W-1:0] wide_mul(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
    logic signed [ACC_W-1:0] wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Q32.32 -> Q16.16, half up, clamped to the signed result range
  function automatic logic [VALUE_BITS-1:0] round_saturate(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = (acc + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > 80'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -80'sd2147483648) return 32'h8000_0000;
    return q[VALUE_BITS-1:0];
  endfunction

  task automatic apply_stencil_word(input logic signed [VALUE_BITS-1:0] x);
    int unsigned w, h, c, r, n, k;
    stencil_point_t found [2];
    logic signed [ACC_W-1:0] acc;
    w = dim_limit(width_cfg, COLS);
    h = dim_limit(height_cfg, ROWS);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    n = 0;
    // the point one row up is complete once the point below it arrives
    if (r >= 2 && c >= 1 && c + 2 <= w) begin
      acc = wide_mul(center_k, newer_row[c])
          + wide_mul(horiz_k, older_row[c-1]) + wide_mul(horiz_k, newer_row[c+1])
          + wide_mul(vert_k, older_row[c]) + wide_mul(vert_k, x);
      found[n] = '{value: round_saturate(acc), column: c[COL_BITS-1:0],
                   row: ROW_BITS'(r - 1), last: 1'b0};
      n++;
    end
    older_row[c] = newer_row[c];
    newer_row[c] = x;
    if (c == 0 || c == w - 1 || r == 0 || r == h - 1) begin
      found[n] = '{value: x, column: c[COL_BITS-1:0], row: r[ROW_BITS-1:0], last: 1'b0};
      n++;
    end
    for (k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      expected_points.push_back(found[k]);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("%0t checker: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_points.delete();
      col_pos    = 0;
      row_pos    = 0;
      width_cfg  = RST_GRID_WIDTH;
      height_cfg = RST_GRID_HEIGHT;
      center_k   = RST_CENTER_COEFF;
      horiz_k    = RST_HORIZ_COEFF;
      vert_k     = RST_VERT_COEFF;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result word, value", '0, out_result_value);
        end else begin
          want = expected_points.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("result_value", want.value, out_result_value);
          if (out_result_column !== want.column)
            report_mismatch("result_column", 32'(want.column), 32'(out_result_column));
          if (out_result_row !== want.row)
            report_mismatch("result_row", 32'(want.row), 32'(out_result_row));
          if (out_last_in_step !== want.last)
            report_mismatch("last_in_step", 32'(want.last), 32'(out_last_in_step));
        end
      end
      if (in_valid && in_ready) apply_stencil_word(in_sample_value);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GRID_WIDTH:   width_cfg = cfg_wdata[DIM_BITS-1:0];
          REG_GRID_HEIGHT:  height_cfg = cfg_wdata[DIM_BITS-1:0];
          REG_CENTER_COEFF: center_k = cfg_wdata[COEFF_BITS-1:0];
          REG_HORIZ_COEFF:  horiz_k = cfg_wdata[COEFF_BITS-1:0];
          REG_VERT_COEFF:   vert_k = cfg_wdata[COEFF_BITS-1:0];
          default: ;
        endcase
      end
    end
    waiting = expected_points.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import fps_pkg::*;

  localparam int COLS     = DEF_MAX_WIDTH;
  localparam int COL_BITS = $clog2(DEF_MAX_WIDTH);
  localparam int ROW_BITS = $clog2(DEF_MAX_HEIGHT);

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]      cfg_index;
  logic [CFG_DATA_BITS-1:0]     cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_sample_value;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [VALUE_BITS-1:0] out_result_value;
  logic [COL_BITS-1:0]          out_result_column;
  logic [ROW_BITS-1:0]          out_result_row;
  logic                         out_last_in_step;

  int fail_count;
  int pending_results;

  // percent of cycles each side sits idle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Shadow of the grid position, kept only so the stimulus never makes the
  // block read a line store entry that was never written.
  logic [DIM_BITS-1:0] width_set  = RST_GRID_WIDTH;
  logic [DIM_BITS-1:0] height_set = RST_GRID_HEIGHT;
  int unsigned         at_col = 0, at_row = 0;
  int unsigned         visits [COLS];  // writes per column, saturates at 2

  int k, guard;

  // 4x3 grid of extreme words, run with the reset coefficients
  logic [VALUE_BITS-1:0] corner_words [12] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  five_point_stencil_operator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_result_column (out_result_column),
    .out_result_row    (out_result_row),
    .out_last_in_step  (out_last_in_step)
  );

  fps_stencil_checker u_checker (.*);

  function automatic int unsigned dim_limit(input logic [DIM_BITS-1:0] v,
                                            input int unsigned ceiling);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  // where the next word lands, after any wrap forced by shrunk dimensions
  function automatic void next_position(output int unsigned c, output int unsigned r);
    c = at_col;
    r = at_row;
    if (c >= dim_limit(width_set, DEF_MAX_WIDTH)) begin
      c = 0;
      r++;
    end
    if (r >= dim_limit(height_set, DEF_MAX_HEIGHT)) r = 0;
  endfunction

  // an interior point reads columns c-1..c+1 of both stores
  function automatic bit next_word_safe();
    int unsigned c, r;
    next_position(c, r);
    if (r < 2 || c < 1 || c + 2 > dim_limit(width_set, DEF_MAX_WIDTH)) return 1'b1;
    return visits[c-1] >= 2 && visits[c] >= 2 && visits[c+1] >= 2;
  endfunction

  function automatic logic [31:0] random_coeff();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return r;
      1: begin
        case (r[1:0])
          2'd0:    return 32'h7FFF_FFFF;
          2'd1:    return 32'h8000_0000;
          2'd2:    return 32'h0000_0000;
          default: return 32'h0001_0000;
        endcase
      end
      default: return {{13{r[18]}}, r[18:0]};  // within +-4.0
    endcase
  endfunction

  // Sends one word. Valid is only dropped when an idle cycle follows, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic send_word(input logic [VALUE_BITS-1:0] v);
    int unsigned c, r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (!in_ready);
    next_position(c, r);
    if (visits[c] < 2) visits[c]++;
    c++;
    if (c >= dim_limit(width_set, DEF_MAX_WIDTH)) begin
      c = 0;
      r++;
      if (r >= dim_limit(height_set, DEF_MAX_HEIGHT)) r = 0;
    end
    at_col = c;
    at_row = r;
  endtask

  // sender holds off until every result is out, then lets the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // dropping cfg_wr_en between writes keeps it to one update per step
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_GRID_WIDTH) width_set = data[DIM_BITS-1:0];
    if (idx == REG_GRID_HEIGHT) height_set = data[DIM_BITS-1:0];
  endtask

  task automatic configure(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
                           input logic [31:0] kc, input logic [31:0] kh,
                           input logic [31:0] kv);
    settle();
    write_reg(REG_GRID_WIDTH, 32'(w));
    write_reg(REG_GRID_HEIGHT, 32'(h));
    write_reg(REG_CENTER_COEFF, kc);
    write_reg(REG_HORIZ_COEFF, kh);
    write_reg(REG_VERT_COEFF, kv);
  endtask

  // Random phases: each picks dimensions and coefficients, then streams a
  // burst of words. Phases start wherever the last one left off, so most
  // dimension changes land mid-grid. A burst ends early rather than step
  // onto store columns that were never filled.
  task automatic run_mode(input int sender_pct, input int receiver_pct, input int quota);
    int sent, count, n;
    logic [DIM_BITS-1:0] w, h;
    logic [31:0] v, r;
    sent = 0;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    while (sent < quota) begin
      case ($urandom_range(19))
        0, 1:    w = $urandom_range(2, 0);   // acts as the minimum
        2:       w = 11'd1024;
        3:       w = 11'd2047;               // acts as the maximum
        4, 5:    w = $urandom_range(40, 11);
        default: w = $urandom_range(10, 3);
      endcase
      case ($urandom_range(9))
        0:       h = $urandom_range(2, 0);
        1:       h = $urandom_range(1) ? 11'd1024 : 11'd2047;
        2:       h = $urandom_range(60, 9);
        default: h = $urandom_range(8, 3);
      endcase
      configure(w, h, random_coeff(), random_coeff(), random_coeff());
      count = $urandom_range(90, 20);
      for (n = 0; n < count && next_word_safe(); n++) begin
        r = $urandom();
        case ($urandom_range(9))
          0: begin
            case (r[2:0])
              3'd0:    v = 32'h7FFF_FFFF;
              3'd1:    v = 32'h8000_0000;
              3'd2:    v = 32'h0000_0000;
              3'd3:    v = 32'hFFFF_FFFF;
              3'd4:    v = 32'h0000_0001;
              3'd5:    v = 32'h0001_0000;
              default: v = 32'hFFFF_0000;
            endcase
          end
          1, 2:    v = r;
          default: v = {{12{r[19]}}, r[19:0]};  // within +-8.0
        endcase
        send_word(v);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_GRID_WIDTH;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extreme words through a 4x3 grid with reset coefficients.
    // Two interior points, both saturating; the middle words of the bottom row
    // complete an interior point and pass through, so two results per word.
    write_reg(REG_GRID_WIDTH, 32'd4);
    write_reg(REG_GRID_HEIGHT, 32'd3);
    for (k = 0; k < 12; k++) send_word(corner_words[k]);

    // Directed: rounding ties on a 5x3 grid, center 0.5 over +-1 LSB with
    // zero neighbors. +0.5 LSB rounds up to 1, -0.5 LSB rounds up to 0.
    // Neighbor coefficients sit at the extremes.
    configure(11'd5, 11'd3, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000);
    for (k = 0; k < 15; k++)
      send_word(k == 6 ? 32'h0000_0001 : (k == 8 ? 32'hFFFF_FFFF : 32'h0000_0000));

    run_mode(19, 68, 450);
    run_mode(68, 19, 450);
    run_mode(0, 0, 450);

    // drain, bounded
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending_results != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fps_pkg.sv
rtl/core/fps_line_buf.sv
rtl/core/fps_kernel.sv
rtl/core/five_point_stencil_operator.sv
verif/fps_stencil_checker.sv
verif/tb.sv
